// ===== design/ssr_pkg.sv =====
// ssr_pkg: shared types, constants and codes of the soft start/stop ramp
// no dependencies; used by the channel interfaces, the divider and the top level

package ssr_pkg;

   // fixed field widths
   localparam int TARGET_W   = 8;
   localparam int MS_W       = 16;
   localparam int BRIGHT_W   = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // default number of fraction bits of the ramp level
   localparam int FRACTION_BITS_DEF = 8;
   localparam int DIVIDEND_W_DEF    = TARGET_W + MS_W + FRACTION_BITS_DEF;

   // register reset values
   localparam logic [TARGET_W-1:0] TARGET_RESET = 8'd255;
   localparam logic [MS_W-1:0]     FADE_RESET   = 16'd0;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_IN_MS   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_OUT_MS  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV,
      ST_UPDATE
   } ssr_state_type;

   typedef struct packed {
      logic start;
   } ssr_div_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } ssr_div_stat_type;

endpackage

// ===== design/ssr_req_if.sv =====
// ssr_req_if: request channel of the ramp (valid/ready plus tick payload)
// depends on ssr_pkg

interface ssr_req_if;
   import ssr_pkg::*;

   logic            valid;
   logic            ready;
   logic [MS_W-1:0] elapsed_ms;
   logic            active;

   modport source (output valid, output elapsed_ms, output active, input ready);
   modport sink   (input valid, input elapsed_ms, input active, output ready);
endinterface

// ===== design/ssr_rsp_if.sv =====
// ssr_rsp_if: response channel of the ramp (valid/ready plus brightness)
// depends on ssr_pkg

interface ssr_rsp_if;
   import ssr_pkg::*;

   logic                valid;
   logic                ready;
   logic [BRIGHT_W-1:0] brightness;

   modport source (output valid, output brightness, input ready);
   modport sink   (input valid, input brightness, output ready);
endinterface

// ===== design/ssr_div.sv =====
// ssr_div: restoring divider, one quotient bit per cycle
// depends on ssr_pkg for the control and status structs

module ssr_div #(
   parameter int DIVIDEND_W = ssr_pkg::DIVIDEND_W_DEF,
   parameter int DIVISOR_W  = ssr_pkg::MS_W
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ssr_pkg::ssr_div_ctrl_type    ctrl,
   input  logic [DIVIDEND_W-1:0]        dividend,
   input  logic [DIVISOR_W-1:0]         divisor,
   output ssr_pkg::ssr_div_stat_type    stat,
   output logic [DIVIDEND_W-1:0]        quotient
);
   import ssr_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] dq_ff, dq_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;

   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   // shift in the next dividend bit and try a subtract
   assign trial = {rem_ff, dq_ff[DIVIDEND_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctrl.start) begin
         dq_in   = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dq_in  = {dq_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = dq_ff;

endmodule

// ===== design/soft_start_stop_ramp_top.sv =====
// soft_start_stop_ramp_top: linear soft start/stop brightness ramp
// depends on ssr_pkg, ssr_req_if, ssr_rsp_if and ssr_div

// Each request is one time tick (elapsed milliseconds and an active flag) and
// gives exactly one response with the integer part of the ramp level. The level
// is kept with FRACTION_BITS fraction bits. While active it rises toward the
// target in steps of target*2^FRACTION_BITS*elapsed/fade_in_ms, while inactive
// it falls toward zero in steps using fade_out_ms; a zero fade time moves at
// once, a nonzero elapsed time moves at least one lsb, and every step clamps.
// A tick that needs a step goes through one shared restoring divider that
// retires one quotient bit per cycle; ticks that hold or jump skip the divider.
// The block takes one request at a time. The response sits in an output register,
// so a new request is accepted while the previous response still waits.
// The user must write registers through the csr port only while the block is
// idle; the block itself does not enforce this.

module soft_start_stop_ramp_top #(
   parameter int FRACTION_BITS = ssr_pkg::FRACTION_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   ssr_req_if.sink                          req,
   ssr_rsp_if.source                        rsp,
   input  logic                             csr_we,
   input  logic [ssr_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ssr_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ssr_pkg::*;

   localparam int LEVEL_W = TARGET_W + FRACTION_BITS;
   localparam int PROD_W  = TARGET_W + MS_W;
   localparam int DIV_W   = PROD_W + FRACTION_BITS;

   // configuration registers
   logic [TARGET_W-1:0] target_ff;
   logic [MS_W-1:0]     fade_in_ff;
   logic [MS_W-1:0]     fade_out_ff;

   // sequencer and tick latch
   ssr_state_type       state_ff, state_in;
   logic [MS_W-1:0]     elapsed_ff;
   logic                active_ff;

   // ramp level and response register
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BRIGHT_W-1:0] bright_ff, bright_in;

   // divider hookup
   ssr_div_ctrl_type    div_ctrl;
   ssr_div_stat_type    div_stat;
   logic [DIV_W-1:0]    div_dividend;
   logic [DIV_W-1:0]    div_quotient;

   logic                req_take;
   logic                rsp_free;
   logic                load;
   logic [LEVEL_W-1:0]  full_scale;
   logic [MS_W-1:0]     fade_sel;
   logic                need_div;
   logic [PROD_W-1:0]   product;
   logic [DIV_W-1:0]    step;
   logic [LEVEL_W-1:0]  headroom;

   // ---------------------------------------------------------------- csr
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff   <= TARGET_RESET;
         fade_in_ff  <= FADE_RESET;
         fade_out_ff <= FADE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_TARGET_LEVEL: target_ff   <= csr_wdata[TARGET_W-1:0];
            CSR_FADE_IN_MS:   fade_in_ff  <= csr_wdata[MS_W-1:0];
            CSR_FADE_OUT_MS:  fade_out_ff <= csr_wdata[MS_W-1:0];
            default:          ;  // unused index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------- datapath
   assign full_scale = {target_ff, {FRACTION_BITS{1'b0}}};
   assign fade_sel   = active_ff ? fade_in_ff : fade_out_ff;

   // a step is only computed when the level can move and the fade is not instant
   assign need_div = active_ff ? ((level_ff < full_scale) && (fade_in_ff != '0))
                               : ((level_ff != '0) && (fade_out_ff != '0));

   // target * elapsed, scaled up by the fraction bits; the divider registers it
   assign product      = PROD_W'(target_ff) * PROD_W'(elapsed_ff);
   assign div_dividend = {product, {FRACTION_BITS{1'b0}}};

   ssr_div #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (MS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (div_ctrl),
      .dividend (div_dividend),
      .divisor  (fade_sel),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   // minimum movement of one lsb for a nonzero tick
   assign step     = ((div_quotient == '0) && (elapsed_ff != '0)) ? DIV_W'(1) : div_quotient;
   assign headroom = full_scale - level_ff;

   always_comb begin
      level_in = level_ff;
      if (active_ff) begin
         if (level_ff < full_scale) begin
            if (fade_in_ff == '0) begin
               level_in = full_scale;
            end else if (DIV_W'(headroom) < step) begin
               level_in = full_scale;
            end else begin
               level_in = level_ff + step[LEVEL_W-1:0];
            end
         end
      end else begin
         if (level_ff != '0) begin
            if (fade_out_ff == '0) begin
               level_in = '0;
            end else if (DIV_W'(level_ff) < step) begin
               level_in = '0;
            end else begin
               level_in = level_ff - step[LEVEL_W-1:0];
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequencer
   assign rsp_free = !rsp_valid_ff || rsp.ready;
   assign req_take = req.valid && req.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req.valid) state_in = ST_EVAL;
         ST_EVAL:   state_in = need_div ? ST_DIV : ST_UPDATE;
         ST_DIV:    if (div_stat.done) state_in = ST_UPDATE;
         ST_UPDATE: if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req.ready      = 1'b0;
      div_ctrl.start = 1'b0;
      load           = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req.ready      = 1'b1;
         ST_EVAL:   div_ctrl.start = need_div;
         ST_DIV:    ;
         ST_UPDATE: load           = rsp_free;
         default:   ;
      endcase
   end

   // response register, freed as soon as the sink takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      bright_in    = bright_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         bright_in    = level_in[LEVEL_W-1:FRACTION_BITS];
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            level_ff <= level_in;
         end
      end
   end

   // tick payload and response data
   always_ff @(posedge clock) begin
      if (req_take) begin
         elapsed_ff <= req.elapsed_ms;
         active_ff  <= req.active;
      end
      bright_ff <= bright_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.brightness = bright_ff;

   // ---------------------------------------------------------------- checks
   // a taken request closes the input until its work is done
   a_req_closes: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req.ready)
      else $error("request accepted while a tick is still in progress");

   // the sequencer only waits on the divider while it is running or finishing
   a_div_alive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_stat.busy || div_stat.done))
      else $error("waiting on an idle divider");

   // a response only appears as the update leaves
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("response raised outside the update step");

   // an inactive tick never raises the level
   a_fade_out_down: assert property (@(posedge clock) disable iff (reset)
      (load && !active_ff) |=> (level_ff <= $past(level_ff)))
      else $error("level rose while inactive");

endmodule

// ===== tb/ssr_ramp_checker.sv =====
// ssr_ramp_checker: watches the tick and brightness channels and the csr port of the ramp,
// predicts every response and compares it; depends on ssr_pkg, ssr_req_if and ssr_rsp_if

module ssr_ramp_checker #(
   parameter int FRACTION_BITS = ssr_pkg::FRACTION_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   ssr_req_if                             req,
   ssr_rsp_if                             rsp,
   input  logic                           csr_we,
   input  logic [ssr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssr_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             pending_count
);
   import ssr_pkg::*;

   localparam int LEVEL_W = TARGET_W + FRACTION_BITS;

   logic [TARGET_W-1:0] cfg_target;
   logic [MS_W-1:0]     cfg_fade_in;
   logic [MS_W-1:0]     cfg_fade_out;
   logic [LEVEL_W-1:0]  ramp_level;
   logic [BRIGHT_W-1:0] brightness_q[$];

   // one tick's move, never less than one lsb once time has passed
   function automatic logic [63:0] fade_delta(input logic [63:0] full,
                                              input logic [MS_W-1:0] elapsed,
                                              input logic [MS_W-1:0] fade);
      logic [63:0] quotient;
      quotient = (full * 64'(elapsed)) / 64'(fade);
      if (quotient == 64'd0 && elapsed != '0)
         quotient = 64'd1;
      return quotient;
   endfunction

   function automatic logic [BRIGHT_W-1:0] advance_ramp(input logic [MS_W-1:0] elapsed,
                                                        input logic rising);
      logic [63:0] full;
      logic [63:0] lvl;
      logic [63:0] delta;
      full = 64'(cfg_target) << FRACTION_BITS;
      lvl  = 64'(ramp_level);
      if (rising) begin
         // a level above the target just holds
         if (lvl < full) begin
            if (cfg_fade_in == '0) begin
               lvl = full;
            end else begin
               delta = fade_delta(full, elapsed, cfg_fade_in);
               lvl   = (full - lvl < delta) ? full : lvl + delta;
            end
         end
      end else if (lvl != 64'd0) begin
         if (cfg_fade_out == '0) begin
            lvl = 64'd0;
         end else begin
            delta = fade_delta(full, elapsed, cfg_fade_out);
            lvl   = (lvl < delta) ? 64'd0 : lvl - delta;
         end
      end
      ramp_level = lvl[LEVEL_W-1:0];
      return ramp_level[LEVEL_W-1 -: BRIGHT_W];
   endfunction

   always @(posedge clock) begin
      logic [BRIGHT_W-1:0] want;
      if (reset) begin
         cfg_target   = TARGET_RESET;
         cfg_fade_in  = FADE_RESET;
         cfg_fade_out = FADE_RESET;
         ramp_level   = '0;
         brightness_q.delete();
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_TARGET_LEVEL: cfg_target   = csr_wdata[TARGET_W-1:0];
               CSR_FADE_IN_MS:   cfg_fade_in  = csr_wdata[MS_W-1:0];
               CSR_FADE_OUT_MS:  cfg_fade_out = csr_wdata[MS_W-1:0];
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (brightness_q.size() == 0) begin
               $display("%0t: unexpected brightness, expected none, got %0d",
                        $time, rsp.brightness);
               fail_count <= fail_count + 1;
            end else begin
               want = brightness_q.pop_front();
               if (rsp.brightness !== want) begin
                  $display("%0t: brightness mismatch, expected %0d, got %0d",
                           $time, want, rsp.brightness);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req.valid && req.ready)
            brightness_q.push_back(advance_ramp(req.elapsed_ms, req.active));
         pending_count <= brightness_q.size();
      end
   end

endmodule

// ===== tb/tb_soft_start_stop_ramp_top.sv =====
// tb_soft_start_stop_ramp_top: stimulus, stalls and verdict for the soft start/stop ramp
// depends on ssr_pkg, ssr_req_if, ssr_rsp_if, soft_start_stop_ramp_top and ssr_ramp_checker

module tb_soft_start_stop_ramp_top;
   import ssr_pkg::*;

   localparam int FRACTION_BITS  = FRACTION_BITS_DEF;
   // no register lives at the last index, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int PHASE_COUNT    = 13;
   localparam int TICKS_PER_PHASE = 150;
   // drain time covers one stepping tick through the divider, plus margin
   localparam int DRAIN_CYCLES   = 60;
   // longest sender gap plus longest receiver stall plus block time, several times over
   localparam int WATCHDOG_LIMIT = 5000;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending_count;
   // when set, neither side inserts gaps or stalls
   logic                  steady_flow;

   ssr_req_if req_ch ();
   ssr_rsp_if rsp_ch ();

   soft_start_stop_ramp_top #(
      .FRACTION_BITS (FRACTION_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ssr_ramp_checker #(
      .FRACTION_BITS (FRACTION_BITS)
   ) ramp_checker (
      .clock         (clock),
      .reset         (reset),
      .req           (req_ch),
      .rsp           (rsp_ch),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // gap length: mostly none or short, now and then a long one
   function automatic int pick_gap();
      int r;
      if (steady_flow)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // fade times: the extremes, short ramps and anything at all
   function automatic logic [MS_W-1:0] pick_fade();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return MS_W'(1);
         2: return '1;
         3, 4, 5, 6: return MS_W'($urandom_range(2, 2000));
         default: return MS_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // elapsed time: mostly small against the fade so ramps take many ticks
   function automatic logic [MS_W-1:0] pick_elapsed(input logic [MS_W-1:0] fade);
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)
         return '0;
      if (r < 12)
         return '1;
      if (r < 25)
         return MS_W'($urandom_range(0, 65535));
      return MS_W'($urandom_range(1, int'(fade) / 64 + 2));
   endfunction

   // one request; returns at the falling edge after acceptance with valid still high
   task automatic send_tick(input logic [MS_W-1:0] elapsed, input logic act);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      = 1'b1;
      req_ch.elapsed_ms = elapsed;
      req_ch.active     = act;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // sender holds off until every expected response has come back
   task automatic wait_drained();
      req_ch.valid = 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // leaves csr_we high; the caller lowers it after the last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
   endtask

   // registers only change while the block is idle
   task automatic program_ramp(input logic [TARGET_W-1:0] target,
                               input logic [MS_W-1:0] fade_in,
                               input logic [MS_W-1:0] fade_out);
      wait_drained();
      // junk in the upper byte of the target write must be dropped
      write_reg(CSR_TARGET_LEVEL, {8'($urandom_range(0, 255)), target});
      write_reg(CSR_FADE_IN_MS, fade_in);
      write_reg(CSR_FADE_OUT_MS, fade_out);
      csr_we = 1'b0;
   endtask

   // receiver side: random stalls on rsp ready
   initial begin : rsp_stall_gen
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ch.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   // ends the run if nothing moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_we)
            quiet = 0;
         else
            quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin : stimulus
      logic [TARGET_W-1:0] target;
      logic [MS_W-1:0]     fade_in;
      logic [MS_W-1:0]     fade_out;
      logic                act;
      int                  run_left;

      reset             = 1'b1;
      steady_flow       = 1'b0;
      csr_we            = 1'b0;
      csr_index         = CSR_TARGET_LEVEL;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.elapsed_ms = '0;
      req_ch.active     = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: full target, instant fades, even with no elapsed time
      send_tick(16'd0, 1'b1);
      send_tick(16'd0, 1'b0);
      send_tick(16'hFFFF, 1'b1);
      send_tick(16'hFFFF, 1'b0);

      // ordinary ramp: hold on zero elapsed, step, clamp at target and at zero
      program_ramp(8'd200, 16'd1000, 16'd500);
      send_tick(16'd0, 1'b1);
      send_tick(16'd1, 1'b1);
      send_tick(16'd100, 1'b1);
      send_tick(16'hFFFF, 1'b1);
      send_tick(16'd0, 1'b1);
      send_tick(16'd1, 1'b0);
      send_tick(16'hFFFF, 1'b0);

      // tiny target against the longest fade: the step rounds to zero, moves one lsb
      program_ramp(8'd1, 16'hFFFF, 16'hFFFF);
      send_tick(16'd1, 1'b1);
      send_tick(16'd1, 1'b0);
      send_tick(16'hFFFF, 1'b1);

      // shortest fade, then hold at the end point
      program_ramp(8'd255, 16'd1, 16'd1);
      send_tick(16'hFFFF, 1'b1);
      send_tick(16'd3, 1'b1);

      // target lowered below the level: active ticks hold; the stray write changes nothing
      program_ramp(8'd100, 16'd1, 16'd1);
      write_reg(CSR_UNUSED, 16'h0005);
      csr_we = 1'b0;
      send_tick(16'hFFFF, 1'b1);
      send_tick(16'd1, 1'b0);

      // zero target with instant fades
      program_ramp(8'd0, 16'd0, 16'd0);
      send_tick(16'd5, 1'b1);
      send_tick(16'd0, 1'b0);

      // random phases, each with its own settings; the level carries over between them
      act      = 1'b1;
      run_left = 0;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               target = 8'd255; fade_in = '1; fade_out = '1;
            end
            1: begin
               target = 8'd0; fade_in = MS_W'(1); fade_out = '1;
            end
            2: begin
               target = 8'd255; fade_in = '0; fade_out = '0;
            end
            default: begin
               case ($urandom_range(0, 4))
                  0: target = 8'd0;
                  1: target = 8'd255;
                  2: target = 8'd1;
                  default: target = 8'($urandom_range(0, 255));
               endcase
               fade_in  = pick_fade();
               fade_out = pick_fade();
            end
         endcase
         program_ramp(target, fade_in, fade_out);
         // every third phase runs back to back on both sides
         steady_flow = (phase % 3 == 1);
         for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            // active comes in runs so ramps get time to travel
            if (run_left == 0) begin
               act      = ($urandom_range(0, 9) < 8) ? ~act : act;
               run_left = $urandom_range(1, 60);
            end
            run_left--;
            send_tick(pick_elapsed(act ? fade_in : fade_out), act);
         end
         steady_flow = 1'b0;
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
